// ----- hdl/s256bh_pkg.sv -----
// Shared types, constants and round functions of the SHA-256 byte stream hasher.
package s256bh_pkg;

  typedef logic [31:0] word_t;

  // Action codes of an input transfer.
  localparam logic ACT_ABSORB = 1'b0;
  localparam logic ACT_FINISH = 1'b1;

  // Byte positions in the 64-byte block and counter end values.
  localparam int unsigned BLK_CNT_W = 55;
  localparam logic [5:0] LAST_BYTE = 6'd63;
  localparam logic [5:0] LEN_POS = 6'd56;
  localparam logic [5:0] LAST_ROUND = 6'd63;
  localparam logic [2:0] LAST_WORD = 3'd7;
  localparam logic [7:0] PAD_BYTE = 8'h80;

  // Initial hash values.
  localparam word_t IV_TAB [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // Round constants.
  localparam word_t K_TAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t rotr(input word_t x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t big_sigma0(input word_t x);
    big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

endpackage

// ----- hdl/s256bh_if.sv -----
// Valid/ready channel interfaces for the input items and the digest words.
interface s256bh_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] data_byte;

  modport source (output valid, output action, output data_byte, input ready);
  modport sink (input valid, input action, input data_byte, output ready);
endinterface

interface s256bh_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, output digest_word, output word_index, output last_word,
                  input ready);
  modport sink (input valid, input digest_word, input word_index, input last_word,
                output ready);
endinterface

// ----- hdl/sha256_byte_stream_hasher.sv -----
// SHA-256 hasher over a byte stream: block buffer, round sequencer and digest output.
//
// Each absorb transfer shifts one byte into a 16-word block register. The transfer
// that completes a 64-byte block is followed by a busy period: the working variables
// are loaded, 64 rounds run through the single round datapath (one round per cycle),
// and the result is folded into the chaining words. A finish transfer appends the
// 0x80 byte, then the padding sequencer shifts in one zero byte per cycle (except
// while a block is compressed) up to byte 56 and then the eight length bytes; when
// the pad byte lands at or after byte 56, an extra block is closed with zeros and
// compressed first. The eight digest words then leave at one per cycle as the sink
// takes them, most significant first, and the block is back to the initial hash
// values for the next message. The input is not ready while a block is being
// compressed, padded or the digest is being sent.
module sha256_byte_stream_hasher (
  input  logic         clk_i,
  input  logic         rst_ni,
  s256bh_in_if.sink    in_i,
  s256bh_out_if.source out_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LEN,
    ST_LOAD,
    ST_ROUND,
    ST_FOLD,
    ST_OUT
  } state_e;

  state_e                                     state_q, ret_q;
  logic [5:0]                                 fill_q;
  logic [s256bh_pkg::BLK_CNT_W-1:0]           blk_q;
  logic [5:0]                                 rnd_q;
  logic [2:0]                                 idx_q;
  logic                                       out_valid_q;
  s256bh_pkg::word_t                          chain_q [8];
  s256bh_pkg::word_t                          win_q [16];
  s256bh_pkg::word_t                          var_q [8];
  logic [63:0]                                len_q;

  logic              in_fire, out_fire;
  logic              shift_en;
  logic [7:0]        shift_byte;
  s256bh_pkg::word_t t1, t2, w_next, ch, maj;

  assign in_fire  = in_i.valid & in_i.ready;
  assign out_fire = out_o.valid & out_o.ready;

  // Byte source for the block register: message, pad byte, zeros or length.
  always_comb begin
    shift_en   = 1'b0;
    shift_byte = 8'h00;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          shift_en   = 1'b1;
          shift_byte = (in_i.action == s256bh_pkg::ACT_FINISH) ? s256bh_pkg::PAD_BYTE
                                                                : in_i.data_byte;
        end
      end
      ST_PAD: begin
        shift_en = (fill_q != s256bh_pkg::LEN_POS);
      end
      ST_LEN: begin
        shift_en   = 1'b1;
        shift_byte = len_q[63:56];
      end
      default: begin
        shift_en = 1'b0;
      end
    endcase
  end

  // One compression round and the schedule word sixteen rounds ahead.
  always_comb begin
    ch  = (var_q[4] & var_q[5]) ^ (~var_q[4] & var_q[6]);
    maj = (var_q[0] & var_q[1]) ^ (var_q[0] & var_q[2]) ^ (var_q[1] & var_q[2]);
    t1  = var_q[7] + s256bh_pkg::big_sigma1(var_q[4]) + ch +
          s256bh_pkg::K_TAB[rnd_q] + win_q[0];
    t2  = s256bh_pkg::big_sigma0(var_q[0]) + maj;
    w_next = win_q[0] + s256bh_pkg::small_sigma0(win_q[1]) + win_q[9] +
             s256bh_pkg::small_sigma1(win_q[14]);
  end

  // Block register, working variables and the latched message length.
  always_ff @(posedge clk_i) begin
    if (shift_en) begin
      for (int i = 0; i < 15; i++) begin
        win_q[i] <= {win_q[i][23:0], win_q[i+1][31:24]};
      end
      win_q[15] <= {win_q[15][23:0], shift_byte};
    end else if (state_q == ST_ROUND) begin
      for (int i = 0; i < 15; i++) begin
        win_q[i] <= win_q[i+1];
      end
      win_q[15] <= w_next;
    end

    if (state_q == ST_LOAD) begin
      for (int i = 0; i < 8; i++) begin
        var_q[i] <= chain_q[i];
      end
    end else if (state_q == ST_ROUND) begin
      var_q[7] <= var_q[6];
      var_q[6] <= var_q[5];
      var_q[5] <= var_q[4];
      var_q[4] <= var_q[3] + t1;
      var_q[3] <= var_q[2];
      var_q[2] <= var_q[1];
      var_q[1] <= var_q[0];
      var_q[0] <= t1 + t2;
    end

    // Block count is a multiple of 512 bits, so the fill count fills the low bits.
    if (state_q == ST_IDLE && in_fire && in_i.action == s256bh_pkg::ACT_FINISH) begin
      len_q <= {blk_q, fill_q, 3'b000};
    end else if (state_q == ST_LEN) begin
      len_q <= {len_q[55:0], 8'h00};
    end
  end

  // Sequencer, counters, chaining words and the output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ret_q       <= ST_IDLE;
      fill_q      <= '0;
      blk_q       <= '0;
      rnd_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < 8; i++) begin
        chain_q[i] <= s256bh_pkg::IV_TAB[i];
      end
    end else begin
      case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            fill_q <= fill_q + 6'd1;
            if (in_i.action == s256bh_pkg::ACT_FINISH) begin
              // A pad byte that completes the block forces an extra compression.
              if (fill_q == s256bh_pkg::LAST_BYTE) begin
                state_q <= ST_LOAD;
                ret_q   <= ST_PAD;
              end else begin
                state_q <= ST_PAD;
              end
            end else if (fill_q == s256bh_pkg::LAST_BYTE) begin
              state_q <= ST_LOAD;
              ret_q   <= ST_IDLE;
              blk_q   <= blk_q + {{(s256bh_pkg::BLK_CNT_W-1){1'b0}}, 1'b1};
            end
          end
        end
        ST_PAD: begin
          if (fill_q == s256bh_pkg::LEN_POS) begin
            state_q <= ST_LEN;
          end else begin
            fill_q <= fill_q + 6'd1;
            if (fill_q == s256bh_pkg::LAST_BYTE) begin
              state_q <= ST_LOAD;
              ret_q   <= ST_PAD;
            end
          end
        end
        ST_LEN: begin
          fill_q <= fill_q + 6'd1;
          if (fill_q == s256bh_pkg::LAST_BYTE) begin
            state_q <= ST_LOAD;
            ret_q   <= ST_OUT;
          end
        end
        ST_LOAD: begin
          rnd_q   <= '0;
          state_q <= ST_ROUND;
        end
        ST_ROUND: begin
          rnd_q <= rnd_q + 6'd1;
          if (rnd_q == s256bh_pkg::LAST_ROUND) begin
            state_q <= ST_FOLD;
          end
        end
        ST_FOLD: begin
          for (int i = 0; i < 8; i++) begin
            chain_q[i] <= chain_q[i] + var_q[i];
          end
          state_q <= ret_q;
          if (ret_q == ST_OUT) begin
            out_valid_q <= 1'b1;
            idx_q       <= '0;
          end
        end
        ST_OUT: begin
          // Digest words shift out of the chain while initial values shift in behind.
          if (out_fire) begin
            for (int i = 0; i < 7; i++) begin
              chain_q[i] <= chain_q[i+1];
            end
            chain_q[7] <= s256bh_pkg::IV_TAB[idx_q];
            idx_q      <= idx_q + 3'd1;
            if (idx_q == s256bh_pkg::LAST_WORD) begin
              out_valid_q <= 1'b0;
              blk_q       <= '0;
              state_q     <= ST_IDLE;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign in_i.ready        = (state_q == ST_IDLE);
  assign out_o.valid       = out_valid_q;
  assign out_o.digest_word = chain_q[0];
  assign out_o.word_index  = idx_q;
  assign out_o.last_word   = (idx_q == s256bh_pkg::LAST_WORD);

endmodule

// ----- hdl/s256bh_checker.sv -----
// Port-level checks of the SHA-256 byte stream hasher and their binding to it.
module s256bh_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        in_action_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] out_word_i,
  input logic [2:0]  out_index_i,
  input logic        out_last_i
);

  logic in_xfer, out_xfer;

  assign in_xfer  = in_valid_i & in_ready_i;
  assign out_xfer = out_valid_i & out_ready_i;

  // The block never takes input while a digest is being sent.
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_i && out_valid_i))
    else $error("input ready while digest words are pending");

  // A finish transfer makes the block busy in the next cycle.
  a_finish_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && in_action_i) |=> !in_ready_i)
    else $error("input ready right after a finish transfer");

  // Digest words follow one another with increasing index until the last.
  a_word_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_xfer && !out_last_i) |=> (out_valid_i && out_index_i == $past(out_index_i) + 3'd1))
    else $error("digest word sequence broken");

  // The transfer of the last word ends the digest.
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_xfer && out_last_i) |=> !out_valid_i)
    else $error("digest words continue after the last word");

  // A stalled digest word holds its value.
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(out_word_i)))
    else $error("stalled digest word changed");

endmodule

bind sha256_byte_stream_hasher s256bh_checker u_s256bh_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_action_i (in_i.action),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_word_i  (out_o.digest_word),
  .out_index_i (out_o.word_index),
  .out_last_i  (out_o.last_word)
);

// ----- tb/sha256_byte_stream_hasher_tb.sv -----
// Testbench for the SHA-256 byte stream hasher: messages checked word by word against a model.
module sha256_byte_stream_hasher_tb;

  // One expected digest word as it should leave the block.
  typedef struct packed {
    logic [31:0] dword;
    logic [2:0]  widx;
    logic        wlast;
  } digest_exp_t;

  // SHA-256 round constants and initial hash values, kept apart from the design's copy.
  localparam logic [31:0] ROUND_CONST [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };
  localparam logic [31:0] START_HASH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  // Quiet cycles after the last digest word, enough for a two-block finish.
  localparam int DRAIN_CYCLES = 300;

  logic clk_i;
  logic rst_ni;

  s256bh_in_if  in_if ();
  s256bh_out_if out_if ();

  sha256_byte_stream_hasher uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  // Predicted hash state.
  logic [31:0] hash_state [8];
  logic [7:0]  blk_bytes [64];
  int unsigned blk_fill;
  logic [63:0] msg_bits;

  digest_exp_t digest_q [$];
  digest_exp_t want;
  int          mismatch_count = 0;
  int          send_idle_pct;
  int          recv_stall_pct;

  // Clock generation.
  initial clk_i = 1'b0;
  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic logic [31:0] ror32(input logic [31:0] x, input int unsigned n);
    logic [63:0] twice;
    twice = {x, x} >> n;
    return twice[31:0];
  endfunction

  function automatic void clear_hash();
    for (int i = 0; i < 8; i++) hash_state[i] = START_HASH[i];
    blk_fill = 0;
    msg_bits = '0;
  endfunction

  // One 64-round compression of blk_bytes into hash_state.
  function automatic void compress_blk();
    logic [31:0] w [64];
    logic [31:0] a, b, c, d, e, f, g, h, t1, t2, s0, s1;
    for (int t = 0; t < 16; t++) begin
      w[t] = {blk_bytes[4*t], blk_bytes[4*t+1], blk_bytes[4*t+2], blk_bytes[4*t+3]};
    end
    for (int t = 16; t < 64; t++) begin
      s0 = ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3);
      s1 = ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10);
      w[t] = w[t-16] + s0 + w[t-7] + s1;
    end
    a = hash_state[0]; b = hash_state[1]; c = hash_state[2]; d = hash_state[3];
    e = hash_state[4]; f = hash_state[5]; g = hash_state[6]; h = hash_state[7];
    for (int t = 0; t < 64; t++) begin
      t1 = h + (ror32(e, 6) ^ ror32(e, 11) ^ ror32(e, 25)) + ((e & f) ^ (~e & g))
           + ROUND_CONST[t] + w[t];
      t2 = (ror32(a, 2) ^ ror32(a, 13) ^ ror32(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    hash_state[0] += a; hash_state[1] += b; hash_state[2] += c; hash_state[3] += d;
    hash_state[4] += e; hash_state[5] += f; hash_state[6] += g; hash_state[7] += h;
  endfunction

  function automatic void hash_absorb(input logic [7:0] data);
    blk_bytes[blk_fill] = data;
    blk_fill++;
    if (blk_fill == 64) begin
      compress_blk();
      msg_bits += 64'd512;
      blk_fill = 0;
    end
  endfunction

  // Pad, compress the last one or two blocks, queue the eight words and restart.
  function automatic void hash_finish();
    logic [63:0] len_bits;
    digest_exp_t de;
    len_bits = msg_bits + 64'(blk_fill) * 64'd8;
    blk_bytes[blk_fill] = 8'h80;
    blk_fill++;
    // No room left for the length field: close this block with zeros first.
    if (blk_fill > 56) begin
      for (int i = blk_fill; i < 64; i++) blk_bytes[i] = 8'h00;
      compress_blk();
      blk_fill = 0;
    end
    for (int i = blk_fill; i < 56; i++) blk_bytes[i] = 8'h00;
    for (int i = 0; i < 8; i++) blk_bytes[63-i] = len_bits[8*i +: 8];
    compress_blk();
    for (int i = 0; i < 8; i++) begin
      de.dword = hash_state[i];
      de.widx  = 3'(i);
      de.wlast = (i == 7);
      digest_q.push_back(de);
    end
    clear_hash();
  endfunction

  // Drive one input item at the falling edge and hold it until the transfer.
  task automatic push_item(input logic act, input logic [7:0] data);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle_pct) begin
      in_if.valid     = 1'b0;
      in_if.data_byte = 8'($urandom);
      @(negedge clk_i);
    end
    in_if.valid     = 1'b1;
    in_if.action    = act;
    in_if.data_byte = data;
    do @(posedge clk_i); while (in_if.ready !== 1'b1);
    if (act == s256bh_pkg::ACT_FINISH) hash_finish();
    else hash_absorb(data);
  endtask

  // Stop sending and hold off until every queued digest word has come out.
  task automatic wait_for_digests();
    @(negedge clk_i);
    in_if.valid = 1'b0;
    while (digest_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_message(input int len);
    for (int i = 0; i < len; i++) push_item(s256bh_pkg::ACT_ABSORB, 8'($urandom));
    push_item(s256bh_pkg::ACT_FINISH, 8'($urandom));
  endtask

  task automatic test_empty_message();
    push_item(s256bh_pkg::ACT_FINISH, 8'hff);
  endtask

  task automatic test_short_text();
    push_item(s256bh_pkg::ACT_ABSORB, 8'h61);
    push_item(s256bh_pkg::ACT_ABSORB, 8'h62);
    push_item(s256bh_pkg::ACT_ABSORB, 8'h63);
    push_item(s256bh_pkg::ACT_FINISH, 8'h00);
  endtask

  task automatic test_byte_extremes();
    push_item(s256bh_pkg::ACT_ABSORB, 8'h00);
    push_item(s256bh_pkg::ACT_ABSORB, 8'hff);
    push_item(s256bh_pkg::ACT_ABSORB, 8'h55);
    push_item(s256bh_pkg::ACT_ABSORB, 8'haa);
    push_item(s256bh_pkg::ACT_ABSORB, 8'h80);
    push_item(s256bh_pkg::ACT_FINISH, 8'h7f);
  endtask

  // Two finishes in a row: the second must hash an empty message from fresh state.
  task automatic test_back_to_back_finish();
    push_item(s256bh_pkg::ACT_FINISH, 8'h00);
    push_item(s256bh_pkg::ACT_FINISH, 8'h80);
  endtask

  // Random messages; a quarter of them sit on the padding and block boundaries.
  // The last message of a phase is cut short so the phase sends exactly its budget.
  task automatic random_phase(input int send_pct, input int stall_pct, input int budget);
    int sent;
    int len;
    send_idle_pct  = send_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < budget) begin
      if ($urandom_range(3) == 0) begin
        case ($urandom_range(7))
          0: len = 55;
          1: len = 56;
          2: len = 57;
          3: len = 63;
          4: len = 64;
          5: len = 65;
          6: len = 119;
          default: len = 120;
        endcase
      end else begin
        len = $urandom_range(12);
      end
      if (len > budget - sent - 1) len = budget - sent - 1;
      send_message(len);
      sent += len + 1;
    end
    wait_for_digests();
  endtask

  // Output side stalls at random.
  always @(negedge clk_i) begin
    out_if.ready = ($urandom_range(99) >= recv_stall_pct);
  end

  // Compare each digest word transfer with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      if (digest_q.size() == 0) begin
        $display("%0t: unexpected digest word %h index %0d last %0b", $time,
                 out_if.digest_word, out_if.word_index, out_if.last_word);
        mismatch_count++;
      end else begin
        want = digest_q.pop_front();
        if (out_if.digest_word !== want.dword) begin
          $display("%0t: digest_word expected %h actual %h", $time, want.dword,
                   out_if.digest_word);
          mismatch_count++;
        end
        if (out_if.word_index !== want.widx) begin
          $display("%0t: word_index expected %0d actual %0d", $time, want.widx,
                   out_if.word_index);
          mismatch_count++;
        end
        if (out_if.last_word !== want.wlast) begin
          $display("%0t: last_word expected %0b actual %0b", $time, want.wlast,
                   out_if.last_word);
          mismatch_count++;
        end
      end
    end
  end

  // Main sequence.
  initial begin
    rst_ni          = 1'b0;
    in_if.valid     = 1'b0;
    in_if.action    = s256bh_pkg::ACT_ABSORB;
    in_if.data_byte = 8'h00;
    out_if.ready    = 1'b0;
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    clear_hash();
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_message();
    test_short_text();
    test_byte_extremes();
    test_back_to_back_finish();
    wait_for_digests();

    random_phase(0, 0, 55);
    random_phase(77, 0, 55);
    random_phase(0, 77, 55);
    random_phase(12, 12, 52);

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #4000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule
